// ----- hdl/snt_pkg.sv -----
// ----------------------------------------------------------------------------
// snt_pkg
// Shared types, widths and codes for the sparse net time step block.
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam int unsigned AREA_W = 8;
  localparam int unsigned UID_W  = 14;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned UCNT_W = 9;
  localparam int unsigned CCNT_W = 11;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned ACC_W  = 32;

  localparam int unsigned DEF_MAX_UNITS = 256;
  localparam int unsigned DEF_MAX_CONNS = 1024;
  localparam int unsigned DEF_FRAC_BITS = 12;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_LOAD_UNIT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_CONN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_ACT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STEP      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_ACT  = 3'd4;

  // configuration register indexes
  localparam logic REG_UNIT_COUNT = 1'b0;
  localparam logic REG_CONN_COUNT = 1'b1;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_LOAD_UNIT = 3'd1,
    OP_LOAD_CONN = 3'd2,
    OP_SET_ACT   = 3'd3,
    OP_STEP      = 3'd4,
    OP_READ_ACT  = 3'd5
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [IDX_W-1:0]        addr;
    logic [AREA_W-1:0]       area_a;
    logic [UID_W-1:0]        unit_a;
    logic [AREA_W-1:0]       area_b;
    logic [UID_W-1:0]        unit_b;
    logic signed [VAL_W-1:0] value;
    logic                    status;
  } qent_t;

  typedef struct packed {
    logic [AREA_W-1:0]       src_area;
    logic [UID_W-1:0]        src_unit;
    logic [AREA_W-1:0]       dst_area;
    logic [UID_W-1:0]        dst_unit;
    logic signed [VAL_W-1:0] weight;
  } conn_t;

endpackage

// ----- hdl/snt_front.sv -----
// ----------------------------------------------------------------------------
// snt_front
// Accepts command transactions, checks the index against the counts in use,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module snt_front #(
  parameter int unsigned UCW = 9,
  parameter int unsigned CCW = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [snt_pkg::CMD_W-1:0]     cmd_i,
  input  logic [snt_pkg::IDX_W-1:0]     index_i,
  input  logic [snt_pkg::AREA_W-1:0]    area_a_i,
  input  logic [snt_pkg::UID_W-1:0]     unit_a_i,
  input  logic [snt_pkg::AREA_W-1:0]    area_b_i,
  input  logic [snt_pkg::UID_W-1:0]     unit_b_i,
  input  logic signed [snt_pkg::VAL_W-1:0] value_i,
  input  logic [UCW-1:0]                units_used_i,
  input  logic [CCW-1:0]                conns_used_i,
  output logic                          q_valid_o,
  output snt_pkg::qent_t                q_ent_o,
  input  logic                          q_pop_i
);
  import snt_pkg::*;

  qent_t      q_mem [2];
  qent_t      ent;
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       unit_ok, conn_ok, push;

  // index range checks
  assign unit_ok = CNT_W'(index_i) < CNT_W'(units_used_i);
  assign conn_ok = CNT_W'(index_i) < CNT_W'(conns_used_i);

  // classify the command
  always_comb begin
    ent        = '0;
    ent.addr   = index_i;
    ent.area_a = area_a_i;
    ent.unit_a = unit_a_i;
    ent.area_b = area_b_i;
    ent.unit_b = unit_b_i;
    ent.value  = value_i;
    ent.op     = OP_NONE;
    ent.status = 1'b0;
    case (cmd_i)
      CMD_LOAD_UNIT: begin
        if (unit_ok) ent.op = OP_LOAD_UNIT;
        else ent.status = 1'b1;
      end
      CMD_LOAD_CONN: begin
        if (conn_ok) ent.op = OP_LOAD_CONN;
        else ent.status = 1'b1;
      end
      CMD_SET_ACT: begin
        if (unit_ok) ent.op = OP_SET_ACT;
        else ent.status = 1'b1;
      end
      CMD_STEP: ent.op = OP_STEP;
      CMD_READ_ACT: begin
        if (unit_ok) ent.op = OP_READ_ACT;
        else ent.status = 1'b1;
      end
      default: ent.op = OP_NONE;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_ent_o    = q_mem[rp_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= ent;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

// ----- hdl/snt_back.sv -----
// ----------------------------------------------------------------------------
// snt_back
// Executes queued operations on the unit and connection tables, runs the
// time step sequencer and drives the result register.
// ----------------------------------------------------------------------------
module snt_back #(
  parameter int unsigned MAX_UNITS = 256,
  parameter int unsigned MAX_CONNS = 1024,
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned UCW       = 9,
  parameter int unsigned CCW       = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [UCW-1:0]                units_used_i,
  input  logic [CCW-1:0]                conns_used_i,
  input  logic                          q_valid_i,
  input  snt_pkg::qent_t                q_ent_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [snt_pkg::VAL_W-1:0] read_value_o,
  output logic                          status_o
);
  import snt_pkg::*;

  localparam int unsigned UW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned CW = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
  localparam logic signed [ACC_W-1:0] TOP =
    (FRAC_BITS > 14) ? ACC_W'(32767) : ACC_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W:0] SAT_MAX = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] SAT_MIN = {2'b11, {(ACC_W-1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_READ    = 9'b000000010,
    S_CONN_RD = 9'b000000100,
    S_MATCH   = 9'b000001000,
    S_OPER_RD = 9'b000010000,
    S_MUL     = 9'b000100000,
    S_ACC     = 9'b001000000,
    S_FIN_RD  = 9'b010000000,
    S_FIN_WR  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // unit id registers, compared in parallel
  logic [AREA_W-1:0] uarea_q [MAX_UNITS];
  logic [UID_W-1:0]  uid_q   [MAX_UNITS];
  logic              tgt_q   [MAX_UNITS];
  logic              newv_q  [MAX_UNITS];

  // memories
  logic signed [VAL_W-1:0] act_old_mem  [MAX_UNITS];
  logic signed [VAL_W-1:0] act_init_mem [MAX_UNITS];
  logic signed [ACC_W-1:0] act_new_mem  [MAX_UNITS];
  conn_t                   conn_mem     [MAX_CONNS];

  logic [CCW-1:0] l_q, l_d;
  logic [UCW-1:0] u_q, u_d;
  logic [UW-1:0]  s_q, t_q;
  logic           hit_q;
  logic signed [VAL_W-1:0] w_q;
  conn_t                   conn_rd_q;
  logic signed [VAL_W-1:0] old_rd_q, init_rd_q;
  logic signed [ACC_W-1:0] new_rd_q, prod_q;
  logic                    newv_rd_q;

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] rv_q;
  logic                    st_q;

  logic           unit_we, conn_we, set_we, fin_we, acc_we, step_start, emit;
  logic [UW-1:0]  q_uaddr, old_raddr, new_raddr;
  logic           src_m [MAX_UNITS];
  logic           dst_m [MAX_UNITS];
  logic [UW-1:0]  s_idx, t_idx;
  logic           s_hit, t_hit;
  logic signed [ACC_W-1:0] prod_sh, acc_base, fin_v, fin_c;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sum_sat;
  logic           fin_tgt;

  assign q_uaddr = UW'(q_ent_i.addr);

  // parallel id match and first-hit priority search
  always_comb begin
    s_idx = '0;
    t_idx = '0;
    s_hit = 1'b0;
    t_hit = 1'b0;
    for (int i = MAX_UNITS - 1; i >= 0; i--) begin
      src_m[i] = (CNT_W'(i) < CNT_W'(units_used_i)) &&
                 (uarea_q[i] == conn_rd_q.src_area) && (uid_q[i] == conn_rd_q.src_unit);
      dst_m[i] = (CNT_W'(i) < CNT_W'(units_used_i)) &&
                 (uarea_q[i] == conn_rd_q.dst_area) && (uid_q[i] == conn_rd_q.dst_unit);
      if (src_m[i]) begin
        s_idx = UW'(i);
        s_hit = 1'b1;
      end
      if (dst_m[i]) begin
        t_idx = UW'(i);
        t_hit = 1'b1;
      end
    end
  end

  // accumulate with floor shift and saturation
  assign prod_sh  = prod_q >>> FRAC_BITS;
  assign acc_base = newv_rd_q ? new_rd_q : '0;
  assign sum      = {acc_base[ACC_W-1], acc_base} + {prod_sh[ACC_W-1], prod_sh};
  always_comb begin
    if (sum > SAT_MAX) sum_sat = SAT_MAX[ACC_W-1:0];
    else if (sum < SAT_MIN) sum_sat = SAT_MIN[ACC_W-1:0];
    else sum_sat = sum[ACC_W-1:0];
  end

  // final pass value selection and clamp
  assign fin_tgt = tgt_q[u_q[UW-1:0]];
  assign fin_v   = fin_tgt ? (newv_rd_q ? new_rd_q : '0) : ACC_W'(init_rd_q);
  always_comb begin
    if (fin_v < 0) fin_c = '0;
    else if (fin_v > TOP) fin_c = TOP;
    else fin_c = fin_v;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    l_d        = l_q;
    u_d        = u_q;
    q_pop_o    = 1'b0;
    unit_we    = 1'b0;
    conn_we    = 1'b0;
    set_we     = 1'b0;
    fin_we     = 1'b0;
    acc_we     = 1'b0;
    step_start = 1'b0;
    emit       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          case (q_ent_i.op)
            OP_LOAD_UNIT: begin
              unit_we = 1'b1;
              emit    = 1'b1;
            end
            OP_LOAD_CONN: begin
              conn_we = 1'b1;
              emit    = 1'b1;
            end
            OP_SET_ACT: begin
              set_we = 1'b1;
              emit   = 1'b1;
            end
            OP_READ_ACT: state_d = S_READ;
            OP_STEP: begin
              step_start = 1'b1;
              l_d = '0;
              u_d = '0;
              if (conns_used_i != '0) state_d = S_CONN_RD;
              else if (units_used_i != '0) state_d = S_FIN_RD;
              else emit = 1'b1;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_READ: begin
        emit    = 1'b1;
        state_d = S_IDLE;
      end
      S_CONN_RD: state_d = S_MATCH;
      S_MATCH:   state_d = S_OPER_RD;
      S_OPER_RD: state_d = S_MUL;
      S_MUL:     state_d = S_ACC;
      S_ACC: begin
        acc_we = hit_q;
        l_d    = l_q + 1'b1;
        if (l_q + 1'b1 == conns_used_i) begin
          state_d = (units_used_i != '0) ? S_FIN_RD : S_IDLE;
          emit    = (units_used_i == '0);
        end else begin
          state_d = S_CONN_RD;
        end
      end
      S_FIN_RD: state_d = S_FIN_WR;
      S_FIN_WR: begin
        fin_we = 1'b1;
        u_d    = u_q + 1'b1;
        if (u_q + 1'b1 == units_used_i) begin
          state_d = S_IDLE;
          emit    = 1'b1;
        end else begin
          state_d = S_FIN_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory read addresses
  assign old_raddr = (state_q == S_IDLE) ? q_uaddr : s_q;
  assign new_raddr = (state_q == S_FIN_RD) ? u_q[UW-1:0] : t_q;

  // act_old memory
  always_ff @(posedge clk_i) begin
    if (unit_we || set_we) act_old_mem[q_uaddr] <= q_ent_i.value;
    else if (fin_we) act_old_mem[u_q[UW-1:0]] <= fin_c[VAL_W-1:0];
    old_rd_q <= act_old_mem[old_raddr];
  end

  // act_init memory
  always_ff @(posedge clk_i) begin
    if (unit_we) act_init_mem[q_uaddr] <= q_ent_i.value;
    init_rd_q <= act_init_mem[u_q[UW-1:0]];
  end

  // act_new memory
  always_ff @(posedge clk_i) begin
    if (acc_we) act_new_mem[t_q] <= sum_sat;
    new_rd_q  <= act_new_mem[new_raddr];
    newv_rd_q <= newv_q[new_raddr];
  end

  // connection memory
  always_ff @(posedge clk_i) begin
    if (conn_we) begin
      conn_mem[CW'(q_ent_i.addr)] <= {q_ent_i.area_a, q_ent_i.unit_a,
                                      q_ent_i.area_b, q_ent_i.unit_b, q_ent_i.value};
    end
    conn_rd_q <= conn_mem[l_q[CW-1:0]];
  end

  // unit ids and per-connection datapath registers
  always_ff @(posedge clk_i) begin
    if (unit_we) begin
      uarea_q[q_uaddr] <= q_ent_i.area_a;
      uid_q[q_uaddr]   <= q_ent_i.unit_a;
    end
    if (state_q == S_MATCH) begin
      s_q   <= s_idx;
      t_q   <= t_idx;
      hit_q <= s_hit && t_hit;
      w_q   <= conn_rd_q.weight;
    end
    if (state_q == S_MUL) prod_q <= ACC_W'(old_rd_q * w_q);
  end

  // target flags and new-value valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_UNITS; i++) begin
        tgt_q[i]  <= 1'b0;
        newv_q[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < MAX_UNITS; i++) begin
        if (step_start && (CNT_W'(i) < CNT_W'(units_used_i))) tgt_q[i] <= 1'b0;
        else if (state_q == S_MATCH && dst_m[i]) tgt_q[i] <= 1'b1;
      end
      if (unit_we) begin
        tgt_q[q_uaddr]  <= 1'b0;
        newv_q[q_uaddr] <= 1'b0;
      end
      if (acc_we) newv_q[t_q] <= 1'b1;
      if (fin_we && fin_tgt) newv_q[u_q[UW-1:0]] <= 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      l_q     <= '0;
      u_q     <= '0;
    end else begin
      state_q <= state_d;
      l_q     <= l_d;
      u_q     <= u_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rv_q <= (state_q == S_READ) ? old_rd_q : '0;
      st_q <= (state_q == S_IDLE) ? q_ent_i.status : 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign status_o     = st_q;

`ifndef SYNTHESIS
  // a transaction leaves the queue only when the result slot is free
  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !out_valid_q) else $error("pop while result pending");

  // a result is never produced over one not yet taken
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !out_valid_q) else $error("result overwritten");

  // accumulation writes only to a unit in use
  a_acc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_we |-> (CNT_W'(t_q) < CNT_W'(units_used_i))) else $error("target out of range");

  // the final pass stays below the unit count
  a_fin_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN_WR) |-> (u_q < units_used_i)) else $error("final pass overrun");
`endif

endmodule

// ----- hdl/sparse_net_timestep.sv -----
// ----------------------------------------------------------------------------
// sparse_net_timestep
// One forward time step of a sparse net held in a unit and a connection table.
// ----------------------------------------------------------------------------
// Each command transaction yields one result. Loads, set and read pass through
// the command queue and the table memories. A step walks every connection in
// use (memory read, parallel id match over all units in use, operand read,
// multiply, accumulate) and then every unit in use (read, clamp and write
// back). Commands keep being queued, up to two, while a step runs. Counts must
// be written only while idle; the block itself does not enforce it.
module sparse_net_timestep #(
  parameter int unsigned MAX_UNITS = snt_pkg::DEF_MAX_UNITS,
  parameter int unsigned MAX_CONNS = snt_pkg::DEF_MAX_CONNS,
  parameter int unsigned FRAC_BITS = snt_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [snt_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [snt_pkg::CMD_W-1:0]     cmd_i,
  input  logic [snt_pkg::IDX_W-1:0]     index_i,
  input  logic [snt_pkg::AREA_W-1:0]    area_a_i,
  input  logic [snt_pkg::UID_W-1:0]     unit_a_i,
  input  logic [snt_pkg::AREA_W-1:0]    area_b_i,
  input  logic [snt_pkg::UID_W-1:0]     unit_b_i,
  input  logic signed [snt_pkg::VAL_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [snt_pkg::VAL_W-1:0] read_value_o,
  output logic                          status_o
);
  import snt_pkg::*;

  localparam int unsigned UCW = $clog2(MAX_UNITS + 1);
  localparam int unsigned CCW = $clog2(MAX_CONNS + 1);

  logic [UCNT_W-1:0] unit_count_q;
  logic [CCNT_W-1:0] conn_count_q;
  logic [UCW-1:0]    units_used;
  logic [CCW-1:0]    conns_used;
  logic              q_valid, q_pop;
  qent_t             q_ent;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_count_q <= '0;
      conn_count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_UNIT_COUNT) unit_count_q <= cfg_data_i[UCNT_W-1:0];
      if (cfg_idx_i == REG_CONN_COUNT) conn_count_q <= cfg_data_i[CCNT_W-1:0];
    end
  end

  // counts capped at the table sizes
  assign units_used = (CNT_W'(unit_count_q) > CNT_W'(MAX_UNITS)) ?
                      UCW'(MAX_UNITS) : UCW'(unit_count_q);
  assign conns_used = (CNT_W'(conn_count_q) > CNT_W'(MAX_CONNS)) ?
                      CCW'(MAX_CONNS) : CCW'(conn_count_q);

  snt_front #(
    .UCW (UCW),
    .CCW (CCW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .index_i      (index_i),
    .area_a_i     (area_a_i),
    .unit_a_i     (unit_a_i),
    .area_b_i     (area_b_i),
    .unit_b_i     (unit_b_i),
    .value_i      (value_i),
    .units_used_i (units_used),
    .conns_used_i (conns_used),
    .q_valid_o    (q_valid),
    .q_ent_o      (q_ent),
    .q_pop_i      (q_pop)
  );

  snt_back #(
    .MAX_UNITS (MAX_UNITS),
    .MAX_CONNS (MAX_CONNS),
    .FRAC_BITS (FRAC_BITS),
    .UCW       (UCW),
    .CCW       (CCW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .units_used_i (units_used),
    .conns_used_i (conns_used),
    .q_valid_i    (q_valid),
    .q_ent_i      (q_ent),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

endmodule
